>>> hdl/smf_pkg.sv
// Shared constants, types and state codes of the sliding-window median filter.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package smf_pkg;
  localparam int MAX_WINDOW = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int WIN_CELLS  = MAX_WINDOW * MAX_WINDOW;
  localparam int PIX_W      = 8;
  localparam int WS_W       = 3;
  localparam int SIZE_W     = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int STEP_W     = $clog2(WIN_CELLS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;
  localparam int LINE_W     = PIX_W * MAX_WINDOW;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WS_W-1:0]   WINDOW_SIZE_RST  = 3'd3;
  localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FEED,
    ST_FLUSH,
    ST_SELECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } sort_cmd_t;
endpackage
`default_nettype wire

>>> hdl/smf_if.sv
// Request channel interfaces of the median filter: pixels in, results out.
// Depends on smf_pkg for field widths.
`default_nettype none
interface smf_pix_if;
  logic                      valid;
  logic                      ready;
  logic [smf_pkg::PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface smf_res_if;
  logic                      valid;
  logic                      ready;
  logic [smf_pkg::PIX_W-1:0] median;
  logic                      last_of_frame;
  modport source (output valid, output median, output last_of_frame, input ready);
  modport sink   (input valid, input median, input last_of_frame, output ready);
endinterface
`default_nettype wire

>>> hdl/sliding_window_median_filter_core.sv
// Top level of the sliding-window median filter: counters, line store, window, sequencer.
// Depends on smf_pkg, smf_if and smf_sorter.
//
// Usage
//   pixels  : one 8-bit grey pixel per request, raster order.
//   results : one request for each window lying wholly inside the image, raster
//             order; last_of_frame marks the final result of a frame.
//   cfg     : write cfg_we/cfg_index/cfg_data only while the block is idle.
// Timing
//   One pixel is taken at a time. A pixel with no result frees the input once
//   the line store has been read and written back. A pixel with a result goes
//   on through the scan of the 7x7 window into the sorter chain, the settling of the
//   chain and the shift down to the median before it reaches the output
//   register.
//   The next pixel is accepted while a result still waits in the output
//   register; a stalled receiver holds the result and blocks the next one.
// Reset
//   rst clears the counters, sequencer and output valid and loads the register
//   defaults (3, 640, 480). The line store and window need no clearing: they
//   are only read where the current frame has already written them.
`default_nettype none
module sliding_window_median_filter_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [smf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [smf_pkg::CFG_DATA_W-1:0] cfg_data,
  smf_pix_if.sink                            pixels,
  smf_res_if.source                          results
);
  localparam int PW = smf_pkg::PIX_W;
  localparam int SW = smf_pkg::SIZE_W;
  localparam int MW = smf_pkg::MAX_WINDOW;
  localparam int WC = smf_pkg::WIN_CELLS;

  // configuration registers
  logic [smf_pkg::WS_W-1:0] window_size;
  logic [SW-1:0]            image_width;
  logic [SW-1:0]            image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= smf_pkg::WINDOW_SIZE_RST;
      image_width  <= smf_pkg::IMAGE_WIDTH_RST;
      image_height <= smf_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        smf_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[smf_pkg::WS_W-1:0];
        smf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        smf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame position, wrapped before and after the pixel is taken
  logic [smf_pkg::COL_W-1:0] column_count;
  logic [smf_pkg::ROW_W-1:0] row_count;
  logic [SW-1:0] wdt, hgt, cw, ch;
  logic [SW-1:0] c_pre, r_tmp, r_pre, c_inc, r_inc, c_post, r_post;
  logic [SW-1:0] w_ext;
  logic          hit, last_hit;

  always_comb begin
    wdt   = (image_width > SW'(smf_pkg::MAX_WIDTH)) ? SW'(smf_pkg::MAX_WIDTH) : image_width;
    hgt   = (image_height > SW'(smf_pkg::MAX_HEIGHT)) ? SW'(smf_pkg::MAX_HEIGHT) : image_height;
    cw    = (wdt == '0) ? SW'(1) : wdt;
    ch    = (hgt == '0) ? SW'(1) : hgt;
    c_pre = SW'(column_count);
    r_tmp = SW'(row_count);
    if (c_pre >= cw) begin
      c_pre = '0;
      r_tmp = r_tmp + SW'(1);
    end
    r_pre = (r_tmp >= ch) ? '0 : r_tmp;
    c_inc = c_pre + SW'(1);
    r_inc = r_pre + SW'(1);
    if (c_inc >= cw) begin
      c_post = '0;
      r_post = (r_inc >= ch) ? '0 : r_inc;
    end else begin
      c_post = c_inc;
      r_post = r_pre;
    end
    w_ext    = SW'(window_size);
    hit      = (window_size != '0) && (w_ext <= wdt) && (w_ext <= hgt) &&
               (c_inc >= w_ext) && (r_inc >= w_ext);
    last_hit = (c_inc == wdt) && (r_inc == hgt);
  end

  // sequencer
  smf_pkg::state_t state, state_next;
  logic                  accept;
  logic [smf_pkg::STEP_W-1:0] step;
  logic                  out_free;

  assign accept   = pixels.valid && pixels.ready;
  assign out_free = !results.valid || results.ready;

  // per-pixel context
  logic [PW-1:0]            px_q;
  logic [smf_pkg::COL_W-1:0] addr_q;
  logic                     hit_q, last_q;
  logic [smf_pkg::WS_W-1:0] lo_q;
  logic [smf_pkg::STEP_W-1:0] half_q;
  logic [smf_pkg::WS_W-1:0] kk, jj;

  always_comb begin
    state_next = state;
    case (state)
      smf_pkg::ST_IDLE:   if (accept) state_next = smf_pkg::ST_LOAD;
      smf_pkg::ST_LOAD:   state_next = hit_q ? smf_pkg::ST_FEED : smf_pkg::ST_IDLE;
      smf_pkg::ST_FEED:   if (step == smf_pkg::STEP_W'(WC - 1)) state_next = smf_pkg::ST_FLUSH;
      smf_pkg::ST_FLUSH:  if (step == smf_pkg::STEP_W'(WC - 1)) state_next = smf_pkg::ST_SELECT;
      smf_pkg::ST_SELECT: if (step == half_q) state_next = smf_pkg::ST_EMIT;
      smf_pkg::ST_EMIT:   if (out_free) state_next = smf_pkg::ST_IDLE;
      default:            state_next = smf_pkg::ST_IDLE;
    endcase
  end

  assign pixels.ready = (state == smf_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step counter restarts on every phase change
  always_ff @(posedge clk) begin
    if (rst || state_next != state) begin
      step <= '0;
      kk   <= '0;
      jj   <= '0;
    end else if (state == smf_pkg::ST_FEED || state == smf_pkg::ST_FLUSH ||
                 state == smf_pkg::ST_SELECT) begin
      step <= step + smf_pkg::STEP_W'(1);
      if (jj == smf_pkg::WS_W'(MW - 1)) begin
        jj <= '0;
        kk <= kk + smf_pkg::WS_W'(1);
      end else begin
        jj <= jj + smf_pkg::WS_W'(1);
      end
    end
  end

  // advance the counters and hold the context of the taken pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      hit_q        <= 1'b0;
    end else if (accept) begin
      column_count <= c_post[smf_pkg::COL_W-1:0];
      row_count    <= r_post[smf_pkg::ROW_W-1:0];
      hit_q        <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_q   <= pixels.pixel;
      addr_q <= c_pre[smf_pkg::COL_W-1:0];
      last_q <= last_hit;
      lo_q   <= smf_pkg::WS_W'(MW) - window_size;
      half_q <= smf_pkg::STEP_W'((6'(window_size) * 6'(window_size)) >> 1);
    end
  end

  // line store: one word per column, seven rows, newest row on top
  logic [smf_pkg::LINE_W-1:0] line_store [smf_pkg::MAX_WIDTH];
  logic [smf_pkg::LINE_W-1:0] line_q, line_new;

  always_ff @(posedge clk) begin
    if (accept) begin
      line_q <= line_store[c_pre[smf_pkg::COL_W-1:0]];
    end
    if (state == smf_pkg::ST_LOAD) begin
      line_store[addr_q] <= line_new;
    end
  end

  // drop the oldest row, push the new pixel on top
  assign line_new = {px_q, line_q[smf_pkg::LINE_W-1:PW]};

  // window: column k at entries k*7 .. k*7+6, newest column last
  logic [PW-1:0] win [WC];

  always_ff @(posedge clk) begin
    if (state == smf_pkg::ST_LOAD) begin
      for (int p = 0; p < WC - MW; p++) begin
        win[p] <= win[p+MW];
      end
      for (int i = 0; i < MW; i++) begin
        win[WC-MW+i] <= line_new[PW*i +: PW];
      end
    end else if (state == smf_pkg::ST_FEED) begin
      // rotate once round; after a full pass the window is unchanged
      for (int p = 0; p < WC - 1; p++) begin
        win[p] <= win[p+1];
      end
      win[WC-1] <= win[0];
    end
  end

  // sorter chain
  smf_pkg::sort_cmd_t cmd;
  logic               feed_valid;
  logic [PW-1:0]      head;

  assign cmd.clear  = (state == smf_pkg::ST_LOAD);
  assign cmd.shift  = (state == smf_pkg::ST_SELECT) && (step != half_q);
  assign feed_valid = (state == smf_pkg::ST_FEED) && (kk >= lo_q) && (jj >= lo_q);

  smf_sorter u_sorter (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .feed_valid (feed_valid),
    .feed_value (win[0]),
    .head       (head)
  );

  // output register
  logic          res_valid;
  logic [PW-1:0] res_median;
  logic          res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == smf_pkg::ST_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == smf_pkg::ST_EMIT && out_free) begin
      res_median <= head;
      res_last   <= last_q;
    end
  end

  assign results.valid         = res_valid;
  assign results.median        = res_median;
  assign results.last_of_frame = res_last;
endmodule
`default_nettype wire

>>> hdl/smf_cell.sv
// One cell of the systolic insertion sorter: keeps the smaller value, hands on the larger.
// Depends on smf_pkg.
`default_nettype none
module smf_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire smf_pkg::sort_cmd_t        cmd,
  input  wire logic                      in_valid,
  input  wire logic [smf_pkg::PIX_W-1:0] in_value,
  input  wire logic [smf_pkg::PIX_W-1:0] right_value,
  output logic [smf_pkg::PIX_W-1:0]      held,
  output logic                           pass_valid,
  output logic [smf_pkg::PIX_W-1:0]      pass_value
);
  logic held_valid;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (cmd.shift) begin
      held       <= right_value;
      pass_valid <= 1'b0;
    end else begin
      pass_valid <= in_valid && held_valid;
      if (in_valid) begin
        if (!held_valid) begin
          held       <= in_value;
          held_valid <= 1'b1;
        end else if (in_value < held) begin
          // keep the smaller, pass the old one onward
          held       <= in_value;
          pass_value <= held;
        end else begin
          pass_value <= in_value;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/smf_sorter.sv
// Chain of sorter cells; after settling cell i holds the i-th smallest value.
// Depends on smf_pkg and smf_cell.
`default_nettype none
module smf_sorter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire smf_pkg::sort_cmd_t        cmd,
  input  wire logic                      feed_valid,
  input  wire logic [smf_pkg::PIX_W-1:0] feed_value,
  output logic [smf_pkg::PIX_W-1:0]      head
);
  localparam int N = smf_pkg::WIN_CELLS;

  logic [smf_pkg::PIX_W-1:0] held  [N];
  logic [smf_pkg::PIX_W-1:0] pval  [N+1];
  logic                      pvld  [N+1];
  logic [smf_pkg::PIX_W-1:0] right [N];

  assign pval[0] = feed_value;
  assign pvld[0] = feed_valid;
  assign head    = held[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_end
      assign right[i] = '0;
    end else begin : g_mid
      assign right[i] = held[i+1];
    end
    smf_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .in_valid    (pvld[i]),
      .in_value    (pval[i]),
      .right_value (right[i]),
      .held        (held[i]),
      .pass_valid  (pvld[i+1]),
      .pass_value  (pval[i+1])
    );
  end
endmodule
`default_nettype wire

>>> hdl/smf_checker.sv
// Port-level checks of the median filter, bound to the top level.
// Depends on smf_pkg and sliding_window_median_filter_core.
`default_nettype none
module smf_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [smf_pkg::PIX_W-1:0] out_median
);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_median))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second pixel taken while one is in work");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_acc))
    else $error("result appeared straight after a pixel");
endmodule

bind sliding_window_median_filter_core smf_checker u_smf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_median (results.median)
);
`default_nettype wire

>>> tb/sv/sliding_window_median_filter_core_tb.sv
// Self-checking testbench of the sliding-window median filter core.
// Depends on smf_pkg and smf_if from the RTL; predicts every median in-line.
`timescale 1ns / 1ps
module sliding_window_median_filter_core_tb;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 200;  // beyond the worst result latency
  localparam int IDLE_PCT = 14;
  localparam int PW = smf_pkg::PIX_W;
  localparam int DW = smf_pkg::CFG_DATA_W;
  localparam int MW = smf_pkg::MAX_WINDOW;

  typedef struct packed {
    logic [smf_pkg::PIX_W-1:0] median;
    logic                      last;
  } median_res_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [smf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [smf_pkg::CFG_DATA_W-1:0] cfg_data;

  smf_pix_if pix_ch ();
  smf_res_if res_ch ();

  sliding_window_median_filter_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (pix_ch),
    .results  (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: column stacks of recent rows, window columns, counters, registers.
  logic [smf_pkg::PIX_W-1:0]  col_stack [smf_pkg::MAX_WINDOW*smf_pkg::MAX_WIDTH];
  logic [smf_pkg::PIX_W-1:0]  win_cols [smf_pkg::WIN_CELLS];
  int unsigned                col_pos, row_pos;
  logic [smf_pkg::WS_W-1:0]   win_side;
  logic [smf_pkg::SIZE_W-1:0] img_w, img_h;

  median_res_t expected_medians[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;  // hold both sides free of idling while set

  // Effective counter bounds: sizes saturate at the maximum, zero counts as one.
  function automatic int unsigned eff_width();
    return (img_w > smf_pkg::MAX_WIDTH) ? smf_pkg::MAX_WIDTH : 32'(img_w);
  endfunction

  function automatic int unsigned eff_height();
    return (img_h > smf_pkg::MAX_HEIGHT) ? smf_pkg::MAX_HEIGHT : 32'(img_h);
  endfunction

  function automatic int unsigned frame_pixels();
    int unsigned cw, ch;
    cw = (eff_width() == 0) ? 1 : eff_width();
    ch = (eff_height() == 0) ? 1 : eff_height();
    return cw * ch;
  endfunction

  // Take one pixel into the predictor and queue the median it completes, if any.
  function automatic void predict_median(input logic [smf_pkg::PIX_W-1:0] px);
    int unsigned wdt, hgt, cw, ch, c, r, w;
    int vals[$];
    median_res_t res;
    wdt = eff_width();
    hgt = eff_height();
    cw = (wdt == 0) ? 1 : wdt;
    ch = (hgt == 0) ? 1 : hgt;
    w = 32'(win_side);
    if (col_pos >= cw) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= ch) row_pos = 0;
    c = col_pos;
    r = row_pos;
    // push the new pixel on top of this column's stack
    for (int k = 0; k + 1 < MW; k++)
      col_stack[c*MW + k] = col_stack[c*MW + k + 1];
    col_stack[c*MW + MW - 1] = px;
    // slide the window one column and load the fresh stack as its newest column
    for (int k = 0; k + 1 < MW; k++)
      for (int i = 0; i < MW; i++)
        win_cols[k*MW + i] = win_cols[(k+1)*MW + i];
    for (int i = 0; i < MW; i++)
      win_cols[(MW-1)*MW + i] = col_stack[c*MW + i];
    if (w >= 1 && w <= MW && w <= wdt && w <= hgt && c + 1 >= w && r + 1 >= w) begin
      for (int k = MW - w; k < MW; k++)
        for (int j = MW - w; j < MW; j++)
          vals.push_back(win_cols[k*MW + j]);
      vals.sort();
      res.median = PW'(vals[vals.size() / 2]);
      res.last = (c + 1 == wdt && r + 1 == hgt);
      expected_medians.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= cw) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= ch) row_pos = 0;
    end
  endfunction

  // Result side: stall at random, compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    res_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result median=%0d last=%0b", $time,
                 res_ch.median, res_ch.last_of_frame);
        fail_count++;
      end else begin
        median_res_t exp_res;
        exp_res = expected_medians.pop_front();
        if (res_ch.median !== exp_res.median) begin
          $display("%0t: median expected %0d actual %0d", $time, exp_res.median,
                   res_ch.median);
          fail_count++;
        end
        if (res_ch.last_of_frame !== exp_res.last) begin
          $display("%0t: last_of_frame expected %0b actual %0b", $time, exp_res.last,
                   res_ch.last_of_frame);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: abandon the run if it outlasts any plausible correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one pixel request, idling at random first, and return once it is accepted.
  task automatic send_pixel(input logic [smf_pkg::PIX_W-1:0] px);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk); while (!pix_ch.ready);
    predict_median(px);
  endtask

  // Drop valid, wait for every predicted median, then let the pipeline settle.
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive one register write; the caller drops the write enable.
  task automatic write_reg(input logic [smf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [smf_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      smf_pkg::REG_WINDOW_SIZE:  win_side = val[smf_pkg::WS_W-1:0];
      smf_pkg::REG_IMAGE_WIDTH:  img_w = val;
      smf_pkg::REG_IMAGE_HEIGHT: img_h = val;
      default: ;
    endcase
  endtask

  // Reconfigure only with the block idle and the counters back at the frame start.
  task automatic set_geometry(input int unsigned w, input int unsigned wd, input int unsigned ht);
    drain_results();
    write_reg(smf_pkg::REG_WINDOW_SIZE, DW'(w));
    write_reg(smf_pkg::REG_IMAGE_WIDTH, DW'(wd));
    write_reg(smf_pkg::REG_IMAGE_HEIGHT, DW'(ht));
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_frame(input int unsigned span);
    for (int unsigned i = 0; i < frame_pixels(); i++) begin
      if (span == 0) send_pixel(PW'($urandom_range(255)));
      else send_pixel(PW'($urandom_range(span)));
    end
  endtask

  // Small frames with hand-picked pixels: full-scale values, single-pixel windows,
  // a disabled window and zero sizes.
  task automatic test_directed();
    logic [smf_pkg::PIX_W-1:0] pix3x5 [15] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55,
                                              8'hAA, 8'h01, 8'hFE, 8'hFF, 8'h00,
                                              8'h0F, 8'hF0, 8'hFF, 8'hFF, 8'h00};
    set_geometry(3, 5, 3);
    foreach (pix3x5[i]) send_pixel(pix3x5[i]);
    set_geometry(1, 2, 2);
    send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'hA5); send_pixel(8'h5A);
    set_geometry(1, 0, 0);  // zero sizes: counters run over one pixel, nothing comes out
    send_pixel(8'h12); send_pixel(8'hED);
    set_geometry(0, 3, 1);  // window disabled
    send_pixel(8'h33); send_pixel(8'hCC); send_pixel(8'h99);
  endtask

  // Oversized width saturates at the maximum row length; every pixel is a result.
  // Run it as one long stretch with no idling on either side.
  task automatic test_max_width();
    set_geometry(1, (1 << smf_pkg::SIZE_W) - 1, 1);
    steady_flow = 1'b1;
    send_random_frame(0);
    steady_flow = 1'b0;
  endtask

  // Largest window on a small image, with random idling on both sides.
  task automatic test_max_window();
    set_geometry(MW, 9, 8);
    send_random_frame(0);
  endtask

  // Random geometries, whole frames each; narrow pixel ranges make ties likely.
  task automatic test_random_frames(input int unsigned target);
    int unsigned sent;
    int unsigned w;
    sent = 0;
    while (sent < target) begin
      w = ($urandom_range(9) == 0) ? 0 : $urandom_range(MW, 1);
      set_geometry(w, $urandom_range(12, (w > 1) ? w - 1 : 0),
                   $urandom_range(10, (w > 1) ? w - 1 : 0));
      steady_flow = ($urandom_range(7) == 0);
      for (int f = $urandom_range(2, 1); f > 0; f--) begin
        send_random_frame(($urandom_range(2) == 0) ? $urandom_range(3) : 0);
        sent += frame_pixels();
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = smf_pkg::REG_WINDOW_SIZE;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    foreach (col_stack[i]) col_stack[i] = '0;
    foreach (win_cols[i]) win_cols[i] = '0;
    col_pos = 0;
    row_pos = 0;
    win_side = smf_pkg::WINDOW_SIZE_RST;
    img_w = smf_pkg::IMAGE_WIDTH_RST;
    img_h = smf_pkg::IMAGE_HEIGHT_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_max_window();
    test_max_width();
    test_random_frames(40);

    drain_results();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
